// ===== design/assert_macros.svh =====
// Assertion macros shared by the page allocator RTL.
// Every macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BPA_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define BPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/bpa_pkg.sv =====
// Package for the bitmap page allocator: sizes, action codes, scan result type.
// No dependencies; used by bpa_byte_scan and bitmap_page_allocator.
`default_nettype none

package bpa_pkg;

	// Sizing
	localparam int NUM_PAGES  = 4096;
	localparam int PAGE_SHIFT = 12;
	localparam int ADDR_W     = 24;
	localparam int COUNT_W    = 13;
	localparam int BB_W       = 10;
	localparam int MAP_BYTES  = NUM_PAGES / 8;
	localparam int MAP_AW     = $clog2(MAP_BYTES);
	localparam int PG_W       = $clog2(NUM_PAGES);
	localparam int FRAME_W    = ADDR_W - PAGE_SHIFT;
	localparam int LIM_W      = PG_W + 1;

	localparam logic [7:0] BYTE_FULL = 8'hFF;

	// Action codes
	localparam logic [1:0] ACT_ALLOC   = 2'd0;
	localparam logic [1:0] ACT_RUN     = 2'd1;
	localparam logic [1:0] ACT_FREE    = 2'd2;
	localparam logic [1:0] ACT_RESERVE = 2'd3;

	// Result of scanning one bitmap byte for a free run
	typedef struct packed {
		logic               found;
		logic [2:0]         end_bit;
		logic [COUNT_W-1:0] run;
	} scan_res_t;

	// Byte mask with bits lo..hi set
	function automatic logic [7:0] byte_mask(input logic [2:0] lo, input logic [2:0] hi);
		logic [7:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			m[b] = (3'(b) >= lo) && (3'(b) <= hi);
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== design/bpa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds the page bitmap.
`default_nettype none

module bpa_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 8,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== design/bpa_byte_scan.sv =====
// Run counter over one bitmap byte: extends the free-page run bit by bit.
// Depends on bpa_pkg.
`default_nettype none

module bpa_byte_scan
	import bpa_pkg::*;
(
	input  wire logic [7:0]         data,
	input  wire logic [COUNT_W-1:0] run_in,
	input  wire logic [COUNT_W-1:0] count,
	output scan_res_t               res
);

	// Walk the eight pages low to high; stop at the first bit that completes the run
	always_comb begin
		logic [COUNT_W-1:0] run;
		logic               found;
		logic [2:0]         eb;
		run   = run_in;
		found = 1'b0;
		eb    = '0;
		for (int b = 0; b < 8; b++) begin
			if (!found) begin
				if (data[b]) begin
					run = '0;
				end else begin
					run = run + 1'b1;
					if (run == count) begin
						found = 1'b1;
						eb    = 3'(b);
					end
				end
			end
		end
		res.found   = found;
		res.end_bit = eb;
		res.run     = run;
	end

endmodule

`default_nettype wire

// ===== design/bitmap_page_allocator.sv =====
// Bitmap first-fit page allocator top level: sequencer, bitmap RAM, byte scanner.
// Depends on bpa_pkg, bpa_ram, bpa_byte_scan and assert_macros.svh.
//
// After reset the block fills the whole bitmap with "used" and holds busy
// high meanwhile. A request is taken when start is high and busy is low;
// busy then stays high until the result strobe done, which lasts exactly
// one cycle and cannot be stalled. An allocation reads the bitmap one byte per
// cycle from byte 0 until it finds the page or run, then marks the run through
// a read-modify-write of the bitmap RAM and returns the result.
// An allocation that finds nothing fails after scanning all bytes in use.
// Free and reserve mark the single page at the address; a request that fails
// at once (zero count, address out of range) leaves the bitmap untouched.
`default_nettype none
`include "assert_macros.svh"

module bitmap_page_allocator
	import bpa_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         action,
	input  wire logic [ADDR_W-1:0]  address,
	input  wire logic [COUNT_W-1:0] count,
	input  wire logic               bitmap_bytes_we,
	input  wire logic [BB_W-1:0]    bitmap_bytes,
	output logic                    done,
	output logic                    ok,
	output logic      [ADDR_W-1:0]  page_address
);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCAN,
		ST_MARK,
		ST_FAIL
	} state_t;

	state_t             state_q;
	logic [BB_W-1:0]    bitmap_bytes_q;
	logic [MAP_AW-1:0]  clr_q;
	logic [BB_W-1:0]    idx_q;
	logic               pv_s1;
	logic [MAP_AW-1:0]  bi_s1;
	logic [COUNT_W-1:0] run_q;
	logic [COUNT_W-1:0] count_q;
	logic [PG_W-1:0]    start_q;
	logic [PG_W-1:0]    end_q;
	logic               set_q;
	logic               alloc_q;
	logic               done_q;
	logic               ok_q;
	logic [ADDR_W-1:0]  page_address_q;

	logic [BB_W-1:0]    lim_bytes;
	logic [LIM_W-1:0]   lim_pages;
	logic [FRAME_W-1:0] frame;
	logic               in_range;
	logic [COUNT_W-1:0] req_count;
	logic [MAP_AW-1:0]  sb;
	logic [MAP_AW-1:0]  eb;
	logic               rd_en;
	logic [7:0]         rd_data;
	logic               wr_en;
	logic [MAP_AW-1:0]  wr_addr;
	logic [7:0]         wr_data;
	logic [7:0]         mask;
	logic [7:0]         mod_data;
	scan_res_t          scan;
	logic [PG_W-1:0]    hit_end;
	logic [COUNT_W-1:0] hit_start;
	logic [PG_W+PAGE_SHIFT-1:0] start_addr;

	// Bytes and pages in use, saturated to the storage size
	assign lim_bytes = (bitmap_bytes_q > BB_W'(MAP_BYTES)) ? BB_W'(MAP_BYTES) : bitmap_bytes_q;
	assign lim_pages = LIM_W'({lim_bytes, 3'b000});
	assign frame     = address[ADDR_W-1:PAGE_SHIFT];
	assign in_range  = LIM_W'(frame) < lim_pages;
	assign req_count = (action == ACT_ALLOC) ? COUNT_W'(1) : count;

	// Byte span of the run being marked
	assign sb = start_q[PG_W-1:3];
	assign eb = end_q[PG_W-1:3];

	// Read issue: scan up to the limit, or walk the run bytes
	always_comb begin
		rd_en = 1'b0;
		case (state_q)
			ST_SCAN: rd_en = idx_q < lim_bytes;
			ST_MARK: rd_en = idx_q <= BB_W'(eb);
			default: rd_en = 1'b0;
		endcase
	end

	// Read-modify-write of the byte returned this cycle
	assign mask     = byte_mask((bi_s1 == sb) ? start_q[2:0] : 3'd0,
		(bi_s1 == eb) ? end_q[2:0] : 3'd7);
	assign mod_data = set_q ? (rd_data | mask) : (rd_data & ~mask);

	// Write port: fill after reset, else write back marked byte
	assign wr_en   = (state_q == ST_INIT) || ((state_q == ST_MARK) && pv_s1);
	assign wr_addr = (state_q == ST_INIT) ? clr_q : bi_s1;
	assign wr_data = (state_q == ST_INIT) ? BYTE_FULL : mod_data;

	bpa_ram #(
		.DEPTH (MAP_BYTES),
		.WIDTH (8)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (idx_q[MAP_AW-1:0]),
		.rd_data (rd_data)
	);

	bpa_byte_scan u_scan (
		.data   (rd_data),
		.run_in (run_q),
		.count  (count_q),
		.res    (scan)
	);

	// Run end and start pages when the scan hits
	assign hit_end    = {bi_s1, scan.end_bit};
	assign hit_start  = COUNT_W'({1'b0, hit_end}) + COUNT_W'(1) - count_q;
	assign start_addr = {start_q, PAGE_SHIFT'(0)};

	// Sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_INIT;
			bitmap_bytes_q <= BB_W'(MAP_BYTES);
			clr_q          <= '0;
			idx_q          <= '0;
			pv_s1          <= 1'b0;
			bi_s1          <= '0;
			run_q          <= '0;
			count_q        <= '0;
			start_q        <= '0;
			end_q          <= '0;
			set_q          <= 1'b0;
			alloc_q        <= 1'b0;
			done_q         <= 1'b0;
			ok_q           <= 1'b0;
			page_address_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (bitmap_bytes_we) begin
				bitmap_bytes_q <= bitmap_bytes;
			end
			pv_s1 <= rd_en;
			if (rd_en) begin
				idx_q <= idx_q + 1'b1;
				bi_s1 <= idx_q[MAP_AW-1:0];
			end
			case (state_q)
				ST_INIT: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == MAP_AW'(MAP_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						pv_s1 <= 1'b0;
						if ((action == ACT_ALLOC) || (action == ACT_RUN)) begin
							count_q <= req_count;
							set_q   <= 1'b1;
							alloc_q <= 1'b1;
							run_q   <= '0;
							idx_q   <= '0;
							state_q <= (req_count == '0) ? ST_FAIL : ST_SCAN;
						end else begin
							start_q <= frame[PG_W-1:0];
							end_q   <= frame[PG_W-1:0];
							idx_q   <= BB_W'(frame[PG_W-1:3]);
							set_q   <= (action == ACT_RESERVE);
							alloc_q <= 1'b0;
							state_q <= in_range ? ST_MARK : ST_FAIL;
						end
					end
				end
				ST_SCAN: begin
					if (pv_s1) begin
						run_q <= scan.run;
					end
					if (pv_s1 && scan.found) begin
						start_q <= hit_start[PG_W-1:0];
						end_q   <= hit_end;
						idx_q   <= BB_W'(hit_start[PG_W-1:3]);
						pv_s1   <= 1'b0;
						state_q <= ST_MARK;
					end else if (!pv_s1 && (idx_q >= lim_bytes)) begin
						state_q <= ST_FAIL;
					end
				end
				ST_MARK: begin
					if (pv_s1 && (bi_s1 == eb)) begin
						done_q         <= 1'b1;
						ok_q           <= 1'b1;
						page_address_q <= alloc_q ? ADDR_W'(start_addr) : '0;
						state_q        <= ST_IDLE;
					end
				end
				ST_FAIL: begin
					done_q         <= 1'b1;
					ok_q           <= 1'b0;
					page_address_q <= '0;
					state_q        <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign ok           = ok_q;
	assign page_address = page_address_q;

	// Checks
	`BPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted but busy not raised")
	`BPA_ASSERT_NEXT(a_done_idle, done && !start, !busy, "still busy after result strobe")
	`BPA_ASSERT(a_wr_state, wr_en, (state_q == ST_INIT) || (state_q == ST_MARK), "bitmap written outside fill or mark")
	`BPA_ASSERT(a_wr_span, wr_en && (state_q == ST_MARK), (bi_s1 >= sb) && (bi_s1 <= eb), "mark write outside run bytes")
	`BPA_ASSERT(a_fail_addr, done && !ok, page_address == '0, "failed request returned an address")

endmodule

`default_nettype wire
